FILE: rtl/core/imufp_pkg.sv
// Package for the IMU frame parser: frame constants, status codes,
// register indexes and the byte-wise CRC-16/X.25 update. No dependencies.
package imufp_pkg;

    localparam logic [7:0]  HDR0       = 8'h55;
    localparam logic [7:0]  HDR1       = 8'hAA;
    localparam logic [7:0]  END_BYTE   = 8'h0A;
    localparam logic [4:0]  LEN_SHORT  = 5'd19;
    localparam logic [4:0]  LEN_QUAT   = 5'd23;
    localparam logic [4:0]  POS_TYPE   = 5'd3;
    localparam logic [4:0]  POS_PAY    = 5'd4;
    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CNT_MAX    = 16'hFFFF;
    localparam logic [7:0]  TYPE_MIN   = 8'd1;
    localparam logic [7:0]  TYPE_MAX   = 8'd4;
    localparam logic [1:0]  KIND_QUAT  = 2'd3;

    localparam logic [7:0]  DEVICE_ID_RST    = 8'd1;
    localparam logic [15:0] RESYNC_LIMIT_RST = 16'd500;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_CRC  = 2'd1,
        ST_TYPE = 2'd2,
        ST_END  = 2'd3
    } status_t;

    typedef enum logic {
        REG_DEVICE_ID    = 1'b0,
        REG_RESYNC_LIMIT = 1'b1
    } reg_idx_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/imu_frame_parser_crc16_top.sv
// IMU serial frame parser with CRC-16/X.25 check, APB config port.
// Depends on imufp_pkg.
//
//  channel  | signals                                  | dir
//  ---------+------------------------------------------+-----
//  input    | in_valid, in_ready, rx_byte              | in
//  result   | out_valid, out_ready, frame_kind,        | out
//           | value_a..value_d, status, sync_lost      |
//  config   | psel, penable, pwrite, paddr, pwdata,    | in
//           | prdata, pready                           |
//
// One byte per cycle while in_ready is high; parse state and CRC update in one pass per transfer.
// A result (at the end byte, or at an unknown type byte) appears in the output register the cycle after that byte.
// in_ready drops only while a held result is not being taken.
// Reset (rst_n, async) clears parse state, failure count and config to defaults.
module imu_frame_parser_crc16_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  frame_kind,
    output logic [31:0] value_a,
    output logic [31:0] value_b,
    output logic [31:0] value_c,
    output logic [31:0] value_d,
    output logic [1:0]  status,
    output logic        sync_lost
);

    logic [7:0]  dev_id_reg;
    logic [15:0] limit_reg;
    logic        cfg_wr;

    logic [4:0]  pos_reg, pos_next;
    logic [7:0]  hdr_reg [3];
    logic [7:0]  hdr_next [3];
    logic [1:0]  kind_reg, kind_next;
    logic [31:0] pay_reg [4];
    logic [31:0] pay_next [4];
    logic [15:0] crc_reg, crc_next;
    logic [15:0] rcrc_reg, rcrc_next;
    logic [15:0] fc_reg, fc_next;

    logic        in_fire;
    logic [4:0]  flen;
    logic [4:0]  pos_off;
    logic [15:0] fc_inc;
    logic        fc_over;

    logic        res_valid;
    logic [1:0]  res_kind;
    logic [31:0] res_a, res_b, res_c, res_d;
    imufp_pkg::status_t res_status;
    logic        res_lost;

    logic        out_valid_reg;
    logic [1:0]  kind_out_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [1:0]  status_reg;
    logic        lost_reg;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_id_reg <= imufp_pkg::DEVICE_ID_RST;
            limit_reg  <= imufp_pkg::RESYNC_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            case (imufp_pkg::reg_idx_t'(paddr[2]))
                imufp_pkg::REG_DEVICE_ID:    dev_id_reg <= pwdata[7:0];
                imufp_pkg::REG_RESYNC_LIMIT: limit_reg  <= pwdata[15:0];
                default:                     dev_id_reg <= dev_id_reg;
            endcase
        end
    end

    always_comb
    begin
        case (imufp_pkg::reg_idx_t'(paddr[2]))
            imufp_pkg::REG_DEVICE_ID:    prdata = {24'd0, dev_id_reg};
            imufp_pkg::REG_RESYNC_LIMIT: prdata = {16'd0, limit_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    // parser
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign flen     = (kind_reg == imufp_pkg::KIND_QUAT) ? imufp_pkg::LEN_QUAT
                                                         : imufp_pkg::LEN_SHORT;
    assign pos_off  = pos_reg - imufp_pkg::POS_PAY;
    assign fc_inc   = (fc_reg == imufp_pkg::CNT_MAX) ? fc_reg : fc_reg + 16'd1;
    assign fc_over  = fc_inc > limit_reg;

    always_comb
    begin
        pos_next   = pos_reg;
        hdr_next   = hdr_reg;
        kind_next  = kind_reg;
        pay_next   = pay_reg;
        crc_next   = crc_reg;
        rcrc_next  = rcrc_reg;
        fc_next    = fc_reg;
        res_valid  = 1'b0;
        res_kind   = 2'd0;
        res_a      = 32'd0;
        res_b      = 32'd0;
        res_c      = 32'd0;
        res_d      = 32'd0;
        res_status = imufp_pkg::ST_OK;
        res_lost   = 1'b0;
        if (in_fire)
        begin
            if (pos_reg < imufp_pkg::POS_TYPE)
            begin
                hdr_next[pos_reg[1:0]] = rx_byte;
                crc_next = imufp_pkg::crc_byte((pos_reg == 5'd0) ? imufp_pkg::CRC_INIT
                                                                 : crc_reg, rx_byte);
                pos_next = pos_reg + 5'd1;
            end
            else if (pos_reg == imufp_pkg::POS_TYPE)
            begin
                if (hdr_reg[0] != imufp_pkg::HDR0 || hdr_reg[1] != imufp_pkg::HDR1 ||
                    hdr_reg[2] != dev_id_reg)
                begin
                    pos_next = 5'd0;
                    crc_next = imufp_pkg::CRC_INIT;
                end
                else if (rx_byte < imufp_pkg::TYPE_MIN || rx_byte > imufp_pkg::TYPE_MAX)
                begin
                    res_valid  = 1'b1;
                    res_status = imufp_pkg::ST_TYPE;
                    res_lost   = fc_over;
                    fc_next    = fc_over ? 16'd0 : fc_inc;
                    pos_next   = 5'd0;
                    crc_next   = imufp_pkg::CRC_INIT;
                end
                else
                begin
                    kind_next = rx_byte[1:0] - 2'd1;
                    crc_next  = imufp_pkg::crc_byte(crc_reg, rx_byte);
                    pos_next  = imufp_pkg::POS_PAY;
                end
            end
            else if (pos_reg >= flen)
            begin
                // stray position: byte starts a new header group
                hdr_next[0] = rx_byte;
                crc_next    = imufp_pkg::crc_byte(imufp_pkg::CRC_INIT, rx_byte);
                pos_next    = 5'd1;
            end
            else if (pos_reg < flen - 5'd3)
            begin
                pay_next[pos_off[3:2]][{pos_off[1:0], 3'b000} +: 8] = rx_byte;
                crc_next = imufp_pkg::crc_byte(crc_reg, rx_byte);
                pos_next = pos_reg + 5'd1;
            end
            else if (pos_reg == flen - 5'd3)
            begin
                rcrc_next = {8'd0, rx_byte};
                pos_next  = pos_reg + 5'd1;
            end
            else if (pos_reg == flen - 5'd2)
            begin
                rcrc_next = {rx_byte, rcrc_reg[7:0]};
                pos_next  = pos_reg + 5'd1;
            end
            else
            begin
                res_valid = 1'b1;
                if (rx_byte != imufp_pkg::END_BYTE)
                    res_status = imufp_pkg::ST_END;
                else if ((crc_reg ^ imufp_pkg::CRC_INIT) != rcrc_reg)
                    res_status = imufp_pkg::ST_CRC;
                else
                    res_status = imufp_pkg::ST_OK;
                if (res_status == imufp_pkg::ST_OK)
                    fc_next = 16'd0;
                else
                begin
                    res_lost = fc_over;
                    fc_next  = fc_over ? 16'd0 : fc_inc;
                end
                res_kind = kind_reg;
                res_a    = pay_reg[0];
                res_b    = pay_reg[1];
                res_c    = pay_reg[2];
                res_d    = (kind_reg == imufp_pkg::KIND_QUAT) ? pay_reg[3] : 32'd0;
                pos_next = 5'd0;
                crc_next = imufp_pkg::CRC_INIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 5'd0;
            hdr_reg  <= '{default: 8'd0};
            kind_reg <= 2'd0;
            pay_reg  <= '{default: 32'd0};
            crc_reg  <= imufp_pkg::CRC_INIT;
            rcrc_reg <= 16'd0;
            fc_reg   <= 16'd0;
        end
        else
        begin
            pos_reg  <= pos_next;
            hdr_reg  <= hdr_next;
            kind_reg <= kind_next;
            pay_reg  <= pay_next;
            crc_reg  <= crc_next;
            rcrc_reg <= rcrc_next;
            fc_reg   <= fc_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire && res_valid)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && res_valid)
        begin
            kind_out_reg <= res_kind;
            a_reg        <= res_a;
            b_reg        <= res_b;
            c_reg        <= res_c;
            d_reg        <= res_d;
            status_reg   <= res_status;
            lost_reg     <= res_lost;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_kind = kind_out_reg;
    assign value_a    = a_reg;
    assign value_b    = b_reg;
    assign value_c    = c_reg;
    assign value_d    = d_reg;
    assign status     = status_reg;
    assign sync_lost  = lost_reg;

    // checks
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < imufp_pkg::LEN_QUAT)
        else $error("byte position out of frame range");

    a_ok_no_lost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == imufp_pkg::ST_OK |-> !lost_reg)
        else $error("sync_lost on a good frame");

    a_ok_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && res_valid && res_status == imufp_pkg::ST_OK
        |=> fc_reg == 16'd0 && out_valid_reg)
        else $error("failure count not cleared after good frame");

    a_lost_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && res_valid && res_lost |=> fc_reg == 16'd0)
        else $error("failure count not cleared after sync loss");

    a_type_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == imufp_pkg::ST_TYPE
        |-> kind_out_reg == 2'd0 && a_reg == 32'd0 && d_reg == 32'd0)
        else $error("unknown type result carries data");

    a_d_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_out_reg != imufp_pkg::KIND_QUAT |-> d_reg == 32'd0)
        else $error("fourth word set on a three-word frame");

endmodule

FILE: sim/imu_frame_parser_crc16_top_tb.sv
// Self-checking testbench for imu_frame_parser_crc16_top: streams framed bytes over the
// input channel, writes registers over APB and checks every frame result in order.
// Depends on imufp_pkg and the parser RTL.
module imu_frame_parser_crc16_top_tb;

    localparam int          IDLE_LIMIT    = 2000;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          MAX_REPORTS   = 10;
    localparam int          FRAME_EXTRA   = 7;
    localparam logic [15:0] CRC_XOROUT    = 16'hFFFF;
    localparam logic [7:0]  TYPE_ACCEL    = imufp_pkg::TYPE_MIN;
    localparam logic [7:0]  TYPE_GYRO     = imufp_pkg::TYPE_MIN + 8'd1;
    localparam logic [7:0]  TYPE_EULER    = imufp_pkg::TYPE_MIN + 8'd2;
    localparam logic [7:0]  TYPE_QUAT     = imufp_pkg::TYPE_MAX;

    typedef enum int {
        DEFECT_NONE,
        DEFECT_CRC,
        DEFECT_END,
        DEFECT_BOTH,
        DEFECT_HEADER,
        DEFECT_SHORT
    } defect_t;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_t;

    typedef struct {
        logic [1:0]          kind;
        logic [31:0]         word_a;
        logic [31:0]         word_b;
        logic [31:0]         word_c;
        logic [31:0]         word_d;
        imufp_pkg::status_t  st;
        logic                lost;
    } frame_result_t;

    class imu_frame_scoreboard;
        logic [7:0]    dev_id;
        logic [15:0]   fail_limit;
        int            pos;
        logic [7:0]    hdr [3];
        logic [1:0]    kind;
        logic [31:0]   words [4];
        logic [15:0]   crc_acc;
        logic [15:0]   crc_rx;
        logic [15:0]   fail_cnt;
        frame_result_t expected_frames [$];
        int            bytes_noted;
        int            frames_checked;
        int            errors;
        int            lost_seen;
        int            status_seen [4];

        function new();
            dev_id = imufp_pkg::DEVICE_ID_RST;
            fail_limit = imufp_pkg::RESYNC_LIMIT_RST;
            pos = 0;
            foreach (hdr[i])
                hdr[i] = '0;
            foreach (words[i])
                words[i] = '0;
            kind = '0;
            crc_acc = imufp_pkg::CRC_INIT;
            crc_rx = '0;
            fail_cnt = '0;
            bytes_noted = 0;
            frames_checked = 0;
            errors = 0;
            lost_seen = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        function void set_reg(imufp_pkg::reg_idx_t idx, logic [31:0] value);
            if (idx == imufp_pkg::REG_DEVICE_ID)
                dev_id = value[7:0];
            else
                fail_limit = value[15:0];
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("ERROR: %s", msg);
        endfunction

        function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c;
            for (int i = 0; i < 8; i++)
            begin
                if (r[0] ^ b[i])
                    r = {1'b0, r[15:1]} ^ imufp_pkg::CRC_POLY;
                else
                    r = {1'b0, r[15:1]};
            end
            return r;
        endfunction

        function bit count_failure();
            if (fail_cnt != imufp_pkg::CNT_MAX)
                fail_cnt++;
            if (fail_cnt > fail_limit)
            begin
                fail_cnt = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void restart();
            pos = 0;
            crc_acc = imufp_pkg::CRC_INIT;
        endfunction

        function void parse_byte(logic [7:0] b);
            int            flen;
            int            off;
            logic [7:0]    type_off;
            frame_result_t res;
            bytes_noted++;
            flen = (kind == imufp_pkg::KIND_QUAT) ? int'(imufp_pkg::LEN_QUAT)
                                                  : int'(imufp_pkg::LEN_SHORT);
            if (pos < int'(imufp_pkg::POS_TYPE))
            begin
                if (pos == 0)
                    crc_acc = imufp_pkg::CRC_INIT;
                hdr[pos] = b;
                crc_acc = crc_step(crc_acc, b);
                pos++;
            end
            else if (pos == int'(imufp_pkg::POS_TYPE))
            begin
                if (hdr[0] != imufp_pkg::HDR0 || hdr[1] != imufp_pkg::HDR1 ||
                    hdr[2] != dev_id)
                    restart();
                else if (b < imufp_pkg::TYPE_MIN || b > imufp_pkg::TYPE_MAX)
                begin
                    res.kind = '0;
                    res.word_a = '0;
                    res.word_b = '0;
                    res.word_c = '0;
                    res.word_d = '0;
                    res.st = imufp_pkg::ST_TYPE;
                    res.lost = count_failure();
                    expected_frames.push_back(res);
                    restart();
                end
                else
                begin
                    type_off = b - imufp_pkg::TYPE_MIN;
                    kind = type_off[1:0];
                    crc_acc = crc_step(crc_acc, b);
                    pos = int'(imufp_pkg::POS_PAY);
                end
            end
            else if (pos >= flen)
            begin
                restart();
                hdr[0] = b;
                crc_acc = crc_step(crc_acc, b);
                pos = 1;
            end
            else if (pos < flen - 3)
            begin
                off = pos - int'(imufp_pkg::POS_PAY);
                words[off / 4][(off % 4) * 8 +: 8] = b;
                crc_acc = crc_step(crc_acc, b);
                pos++;
            end
            else if (pos == flen - 3)
            begin
                crc_rx = {8'h00, b};
                pos++;
            end
            else if (pos == flen - 2)
            begin
                crc_rx[15:8] = b;
                pos++;
            end
            else
            begin
                if (b != imufp_pkg::END_BYTE)
                    res.st = imufp_pkg::ST_END;
                else if ((crc_acc ^ CRC_XOROUT) != crc_rx)
                    res.st = imufp_pkg::ST_CRC;
                else
                    res.st = imufp_pkg::ST_OK;
                if (res.st == imufp_pkg::ST_OK)
                begin
                    fail_cnt = '0;
                    res.lost = 1'b0;
                end
                else
                    res.lost = count_failure();
                res.kind = kind;
                res.word_a = words[0];
                res.word_b = words[1];
                res.word_c = words[2];
                res.word_d = (kind == imufp_pkg::KIND_QUAT) ? words[3] : '0;
                expected_frames.push_back(res);
                restart();
            end
        endfunction

        function void check_frame(frame_result_t got);
            frame_result_t want;
            if (expected_frames.size() == 0)
            begin
                note_error($sformatf("unexpected result kind=%0d status=%0d",
                                     got.kind, got.st));
                return;
            end
            want = expected_frames.pop_front();
            frames_checked++;
            status_seen[int'(want.st)]++;
            if (want.lost)
                lost_seen++;
            if (got.kind !== want.kind || got.word_a !== want.word_a ||
                got.word_b !== want.word_b || got.word_c !== want.word_c ||
                got.word_d !== want.word_d || got.st !== want.st || got.lost !== want.lost)
                note_error($sformatf({"result %0d exp kind=%0d %h %h %h %h st=%0d lost=%0b",
                                      " got kind=%0d %h %h %h %h st=%0d lost=%0b"},
                                     frames_checked, want.kind, want.word_a, want.word_b,
                                     want.word_c, want.word_d, want.st, want.lost,
                                     got.kind, got.word_a, got.word_b, got.word_c,
                                     got.word_d, got.st, got.lost));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  frame_kind;
    logic [31:0] value_a;
    logic [31:0] value_b;
    logic [31:0] value_c;
    logic [31:0] value_d;
    logic [1:0]  status;
    logic        sync_lost;

    imu_frame_scoreboard frame_sb;
    frame_result_t       seen;
    bit                  sender_steady = 1'b0;
    bit                  receiver_steady = 1'b0;
    int                  burst_left = 0;

    imu_frame_parser_crc16_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_kind (frame_kind),
        .value_a    (value_a),
        .value_b    (value_b),
        .value_c    (value_c),
        .value_d    (value_d),
        .status     (status),
        .sync_lost  (sync_lost)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen.kind = frame_kind;
            seen.word_a = value_a;
            seen.word_b = value_b;
            seen.word_c = value_c;
            seen.word_d = value_d;
            seen.st = imufp_pkg::status_t'(status);
            seen.lost = sync_lost;
            frame_sb.check_frame(seen);
        end
    end

    initial
    begin : receiver_pattern
        int hold;
        int pick;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (receiver_steady)
                out_ready <= 1'b1;
            else if (hold > 0)
                hold--;
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                begin
                    out_ready <= 1'b1;
                    hold = $urandom_range(1, 16);
                end
                else if (pick < 9)
                begin
                    out_ready <= 1'b0;
                    hold = $urandom_range(1, 4);
                end
                else
                begin
                    out_ready <= 1'b0;
                    hold = $urandom_range(5, 12);
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("ERROR: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (sender_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        frame_sb.parse_byte(b);
    endtask

    task automatic stop_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (frame_sb.expected_frames.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input imufp_pkg::reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        frame_sb.set_reg(idx, value);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic read_reg(input imufp_pkg::reg_idx_t idx);
        logic [31:0] want;
        logic [31:0] got;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == imufp_pkg::REG_DEVICE_ID)
        begin
            want = {24'h0, frame_sb.dev_id};
            got = {24'h0, prdata[7:0]};
        end
        else
        begin
            want = {16'h0, frame_sb.fail_limit};
            got = {16'h0, prdata[15:0]};
        end
        if (got !== want)
            frame_sb.note_error($sformatf("register %s read %h, exp %h",
                                          idx.name(), got, want));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reconfigure(input logic [7:0] id, input logic [15:0] limit);
        stop_input();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(imufp_pkg::REG_DEVICE_ID, {24'h0, id});
        write_reg(imufp_pkg::REG_RESYNC_LIMIT, {16'h0, limit});
        read_reg(imufp_pkg::REG_DEVICE_ID);
        read_reg(imufp_pkg::REG_RESYNC_LIMIT);
    endtask

    function automatic logic [7:0] unknown_type();
        logic [7:0] t;
        do
            t = 8'($urandom_range(0, 255));
        while (t >= imufp_pkg::TYPE_MIN && t <= imufp_pkg::TYPE_MAX);
        return t;
    endfunction

    // feed filler until the parser sits at a group boundary
    task automatic realign();
        int tries;
        tries = 0;
        while (frame_sb.pos != 0 && tries < 64)
        begin
            send_byte(8'($urandom_range(0, 255)));
            tries++;
        end
    endtask

    task automatic send_frame(input logic [7:0] type_byte, input defect_t defect,
                              input fill_t fill);
        logic [7:0]  fb [$];
        logic [15:0] crc;
        logic [15:0] crc_flip;
        logic [7:0]  flip;
        int          nbytes;
        int          idx;
        realign();
        fb = {imufp_pkg::HDR0, imufp_pkg::HDR1, frame_sb.dev_id, type_byte};
        if (type_byte >= imufp_pkg::TYPE_MIN && type_byte <= imufp_pkg::TYPE_MAX)
        begin
            nbytes = ((type_byte == TYPE_QUAT) ? int'(imufp_pkg::LEN_QUAT)
                                               : int'(imufp_pkg::LEN_SHORT)) - FRAME_EXTRA;
            repeat (nbytes)
            begin
                if (fill == FILL_ZERO)
                    fb.push_back(8'h00);
                else if (fill == FILL_ONES)
                    fb.push_back(8'hFF);
                else
                    fb.push_back(8'($urandom_range(0, 255)));
            end
            crc = imufp_pkg::CRC_INIT;
            foreach (fb[i])
                crc = frame_sb.crc_step(crc, fb[i]);
            crc = crc ^ CRC_XOROUT;
            if (defect == DEFECT_CRC || defect == DEFECT_BOTH)
            begin
                crc_flip = 16'($urandom_range(1, 65535));
                crc = crc ^ crc_flip;
            end
            fb.push_back(crc[7:0]);
            fb.push_back(crc[15:8]);
            flip = 8'($urandom_range(1, 255));
            if (defect == DEFECT_END || defect == DEFECT_BOTH)
                fb.push_back(imufp_pkg::END_BYTE ^ flip);
            else
                fb.push_back(imufp_pkg::END_BYTE);
            if (defect == DEFECT_SHORT)
                repeat ($urandom_range(1, fb.size() - 5)) void'(fb.pop_back());
        end
        if (defect == DEFECT_HEADER)
        begin
            idx = $urandom_range(0, 2);
            flip = 8'($urandom_range(1, 255));
            fb[idx] = fb[idx] ^ flip;
        end
        foreach (fb[i])
            send_byte(fb[i]);
    endtask

    task automatic run_random(input int target);
        int         stop_at;
        int         pick;
        logic [7:0] t;
        stop_at = frame_sb.bytes_noted + target;
        while (frame_sb.bytes_noted < stop_at)
        begin
            pick = $urandom_range(0, 99);
            t = imufp_pkg::TYPE_MIN + 8'($urandom_range(0, 3));
            if (pick < 58)
                send_frame(t, DEFECT_NONE, FILL_RANDOM);
            else if (pick < 68)
                send_frame(t, DEFECT_CRC, FILL_RANDOM);
            else if (pick < 73)
                send_frame(t, DEFECT_END, FILL_RANDOM);
            else if (pick < 76)
                send_frame(t, DEFECT_BOTH, FILL_RANDOM);
            else if (pick < 82)
                send_frame(t, DEFECT_HEADER, FILL_RANDOM);
            else if (pick < 89)
                send_frame(unknown_type(), DEFECT_NONE, FILL_RANDOM);
            else if (pick < 94)
                send_frame(t, DEFECT_SHORT, FILL_RANDOM);
            else if (pick < 96)
            begin
                stop_input();
                wait_drained();
            end
            else
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin : stimulus
        frame_sb = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        rx_byte = '0;
        out_ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        read_reg(imufp_pkg::REG_DEVICE_ID);
        read_reg(imufp_pkg::REG_RESYNC_LIMIT);

        send_frame(TYPE_ACCEL, DEFECT_NONE, FILL_ZERO);
        send_frame(TYPE_GYRO, DEFECT_NONE, FILL_ONES);
        send_frame(TYPE_EULER, DEFECT_NONE, FILL_RANDOM);
        send_frame(TYPE_QUAT, DEFECT_NONE, FILL_ONES);
        send_frame(TYPE_ACCEL, DEFECT_NONE, FILL_RANDOM);
        send_frame(TYPE_QUAT, DEFECT_NONE, FILL_ZERO);
        send_frame(TYPE_GYRO, DEFECT_CRC, FILL_RANDOM);
        send_frame(TYPE_EULER, DEFECT_END, FILL_RANDOM);
        send_frame(TYPE_QUAT, DEFECT_BOTH, FILL_RANDOM);
        repeat (3) send_frame(TYPE_ACCEL, DEFECT_HEADER, FILL_RANDOM);
        send_frame(8'h00, DEFECT_NONE, FILL_RANDOM);
        send_frame(imufp_pkg::TYPE_MAX + 8'd1, DEFECT_NONE, FILL_RANDOM);
        send_frame(8'hFF, DEFECT_NONE, FILL_RANDOM);
        send_frame(TYPE_QUAT, DEFECT_SHORT, FILL_RANDOM);
        send_frame(TYPE_GYRO, DEFECT_NONE, FILL_RANDOM);

        run_random(450);
        reconfigure(8'h00, 16'h0000);
        run_random(350);
        reconfigure(8'hFF, 16'd3);
        run_random(350);
        reconfigure(8'($urandom_range(0, 255)), 16'($urandom_range(1, 20)));
        run_random(300);

        // back-to-back failures against a small limit
        reconfigure(frame_sb.dev_id, 16'd2);
        sender_steady = 1'b1;
        receiver_steady = 1'b1;
        repeat (6) send_frame(unknown_type(), DEFECT_NONE, FILL_RANDOM);
        send_frame(TYPE_QUAT, DEFECT_NONE, FILL_RANDOM);
        send_frame(unknown_type(), DEFECT_NONE, FILL_RANDOM);
        sender_steady = 1'b0;
        receiver_steady = 1'b0;

        stop_input();
        wait_drained();
        repeat (8) @(posedge clk);
        if (frame_sb.expected_frames.size() != 0)
            frame_sb.note_error($sformatf("%0d results never arrived",
                                          frame_sb.expected_frames.size()));
        $display("Run: %0d byte transfers, %0d results (ok %0d, crc %0d, type %0d, end %0d)",
                 frame_sb.bytes_noted, frame_sb.frames_checked, frame_sb.status_seen[0],
                 frame_sb.status_seen[1], frame_sb.status_seen[2], frame_sb.status_seen[3]);
        $display("%0d results flagged sync loss over five register settings, %0d errors",
                 frame_sb.lost_seen, frame_sb.errors);
        if (frame_sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/imufp_pkg.sv
rtl/core/imu_frame_parser_crc16_top.sv
sim/imu_frame_parser_crc16_top_tb.sv
